### rtl/core/firlp_pkg.sv
// Package for the 64-tap low-pass FIR: payload structs, MAC control struct
// and the fixed coefficient design table with its quantizer.
// No dependencies.
package firlp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int HALF_TABLE = 32;
   localparam int DESIGN_TAPS = 64;
   localparam int ROM_AW = 6;
   localparam longint unsigned DECIMAL_SCALE = 64'd100000000;

   // First half of the symmetric design, in units of 1e-8.
   localparam logic [31:0] HALF_DESIGN [HALF_TABLE] = '{
      32'd212772,  32'd220480,  32'd240508,  32'd272921,
      32'd317643,  32'd374454,  32'd442991,  32'd522754,
      32'd613105,  32'd713279,  32'd822388,  32'd939434,
      32'd1063316, 32'd1192843, 32'd1326749, 32'd1463704,
      32'd1602331, 32'd1741222, 32'd1878951, 32'd2014096,
      32'd2145249, 32'd2271036, 32'd2390133, 32'd2501279,
      32'd2603293, 32'd2695089, 32'd2775685, 32'd2844218,
      32'd2899951, 32'd2942284, 32'd2970763, 32'd2985080
   };

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          last_out;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic step_last;
      logic clear;
   } mac_ctrl_type;

   // Quantize design tap k to Q1.(coef_bits-1), round half up.
   function automatic logic [31:0] coef_quant(int unsigned k, int unsigned coef_bits);
      logic [63:0] d;
      logic [63:0] q;
      d = 64'(HALF_DESIGN[(k < HALF_TABLE) ? k : (DESIGN_TAPS - 1 - k)]);
      q = ((d << (coef_bits - 1)) + (DECIMAL_SCALE / 2)) / DECIMAL_SCALE;
      return q[31:0];
   endfunction

endpackage

### rtl/core/firlp_tap_cell.sv
// One cell of the sample ring: holds one sample and takes its neighbor's
// value on each shift. Depends on firlp_pkg.
module firlp_tap_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   shift_en,
   input  logic signed [firlp_pkg::SAMPLE_BITS-1:0] sample_d,
   output logic signed [firlp_pkg::SAMPLE_BITS-1:0] sample_q
);

   logic signed [firlp_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [firlp_pkg::SAMPLE_BITS-1:0] sample_in;

   always_comb begin
      sample_in = shift_en ? sample_d : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_q = sample_ff;

endmodule

### rtl/core/firlp_mac.sv
// Shared multiply-accumulate for the FIR: operand register, product
// register, accumulator, then rounding and saturation. Depends on firlp_pkg.
module firlp_mac #(
   parameter int TAP_COUNT = 64,
   parameter int COEF_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  firlp_pkg::mac_ctrl_type                  ctrl,
   input  logic signed [firlp_pkg::SAMPLE_BITS-1:0] tap_sample,
   input  logic        [COEF_BITS-1:0]              tap_coef,
   output logic                                     done,
   output logic signed [firlp_pkg::SAMPLE_BITS-1:0] result
);

   localparam int SB = firlp_pkg::SAMPLE_BITS;
   localparam int PROD_W = SB + COEF_BITS + 1;
   localparam int ACC_W = PROD_W + $clog2(TAP_COUNT);

   logic                     v1_ff, e1_ff, v2_ff, e2_ff, done_ff;
   logic signed [SB-1:0]     tap_ff;
   logic [COEF_BITS-1:0]     coef_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  rnd_sum;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [ACC_W-1:0]  sat_hi;
   logic signed [ACC_W-1:0]  sat_lo;

   always_comb begin
      prod_in = PROD_W'(tap_ff) * PROD_W'($signed({1'b0, coef_ff}));
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         e1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         e2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= ctrl.step;
         e1_ff   <= ctrl.step & ctrl.step_last;
         v2_ff   <= v1_ff;
         e2_ff   <= v1_ff & e1_ff;
         done_ff <= v2_ff & e2_ff;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_sample;
      coef_ff <= tap_coef;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Round half up, drop the fraction, clamp to the sample range.
   always_comb begin
      sat_hi  = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
      sat_lo  = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
      rnd_sum = acc_ff + (ACC_W'(1) <<< (COEF_BITS - 2));
      shifted = rnd_sum >>> (COEF_BITS - 1);
      if (shifted > sat_hi) begin
         result = sat_hi[SB-1:0];
      end else if (shifted < sat_lo) begin
         result = sat_lo[SB-1:0];
      end else begin
         result = shifted[SB-1:0];
      end
   end

   assign done = done_ff;

endmodule

### rtl/core/fir_lowpass_filter_64tap_top.sv
// Top level of the 64-tap low-pass FIR: sample ring of tap cells,
// coefficient table, control sequencer and output register.
// Depends on firlp_pkg, firlp_tap_cell, firlp_mac.
//
//   port group  dir  payload             transfer when
//   req_        in   firlp_pkg::req_type req_valid && req_ready
//   rsp_        out  firlp_pkg::rsp_type rsp_valid && rsp_ready
//
// For each sample the ring of TAP_COUNT cells rotates once past a single
// shared multiplier, one tap per cycle, then the MAC pipeline drains;
// the next sample is taken only once the sequencer is back in idle.
// Reset (synchronous) clears the ring to zeros and empties the output.
// A finished sample waits in the output register; a new sample may enter
// meanwhile, and the sequencer holds its next result until the slot frees.
module fir_lowpass_filter_64tap_top #(
   parameter int TAP_COUNT = 64,
   parameter int COEF_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  firlp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output firlp_pkg::rsp_type rsp_data
);

   localparam int SB = firlp_pkg::SAMPLE_BITS;
   localparam int CNT_W = $clog2(TAP_COUNT);
   localparam int IDX_W = (CNT_W > firlp_pkg::ROM_AW) ? CNT_W : firlp_pkg::ROM_AW + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   firlp_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                 accept;
   logic                 shift_en;
   logic signed [SB-1:0] head_d;
   logic signed [SB-1:0] ring_q [TAP_COUNT];
   logic [COEF_BITS-1:0] coef_rom [firlp_pkg::DESIGN_TAPS];
   logic [IDX_W-1:0]     tap_idx;
   logic [COEF_BITS-1:0] coef_sel;
   firlp_pkg::mac_ctrl_type mac_ctrl;
   logic                 mac_done;
   logic signed [SB-1:0] mac_result;

   // Coefficient table, fixed at elaboration.
   for (genvar k = 0; k < firlp_pkg::DESIGN_TAPS; k++) begin : g_rom
      assign coef_rom[k] = COEF_BITS'(firlp_pkg::coef_quant(k, COEF_BITS));
   end

   assign accept   = req_valid && req_ready;
   assign shift_en = accept || (state_ff == ST_RUN);
   // Load a new sample on transfer, otherwise rotate the tail back to the head.
   assign head_d   = accept ? req_data.sample_in : ring_q[TAP_COUNT-1];

   for (genvar i = 0; i < TAP_COUNT; i++) begin : g_ring
      firlp_tap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .sample_d ((i == 0) ? head_d : ring_q[(i == 0) ? 0 : i - 1]),
         .sample_q (ring_q[i])
      );
   end

   // The tail holds x[n-cnt] while the ring turns.
   always_comb begin
      tap_idx  = IDX_W'(cnt_ff);
      coef_sel = '0;
      if (tap_idx < IDX_W'(firlp_pkg::DESIGN_TAPS)) begin
         coef_sel = coef_rom[tap_idx[firlp_pkg::ROM_AW-1:0]];
      end
      mac_ctrl.step      = (state_ff == ST_RUN);
      mac_ctrl.step_last = (cnt_ff == '0);
      mac_ctrl.clear     = accept;
   end

   firlp_mac #(
      .TAP_COUNT (TAP_COUNT),
      .COEF_BITS (COEF_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .tap_sample (ring_q[TAP_COUNT-1]),
      .tap_coef   (coef_sel),
      .done       (mac_done),
      .result     (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = (state_ff == ST_IDLE);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = CNT_W'(TAP_COUNT - 1);
               last_in  = req_data.last_in;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the result until the output slot frees.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sample_out = mac_result;
               rsp_data_in.last_out   = last_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (cnt_ff == CNT_W'(TAP_COUNT - 1)))
      else $error("sequencer did not start a full ring pass after transfer");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("MAC finished outside the drain phase");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) && (state_ff == ST_FINISH) |=> rsp_valid_ff
         && (state_ff == ST_IDLE))
      else $error("finished result not moved to the output register");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) || (state_ff == ST_DRAIN) |-> !req_ready)
      else $error("input ready while the ring is in use");

endmodule

### dv/tb_fir_lowpass_filter_64tap_top.sv
// Self-checking testbench for fir_lowpass_filter_64tap_top: directed samples from a table,
// then random framed streams; each result is checked against a bit-true convolution model
// or a typed-in value. Depends on firlp_pkg and the RTL top level.
module tb_fir_lowpass_filter_64tap_top;

   localparam int TAPS = 64;
   localparam int HALF_TAPS = 32;
   localparam int FRAC_BITS = 15;
   localparam longint DESIGN_SCALE = 64'd100000000;
   localparam int IDLE_PCT_DEFAULT = 11;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int RANDOM_ITEMS = 550;
   localparam int LIMIT_CYCLES = 400000;
   localparam int NUM_PROBES = 22;

   // Low-pass design, first half of the symmetric set, in units of 1e-8.
   localparam longint LOWPASS_HALF [HALF_TAPS] = '{
      212772,  220480,  240508,  272921,  317643,  374454,  442991,  522754,
      613105,  713279,  822388,  939434,  1063316, 1192843, 1326749, 1463704,
      1602331, 1741222, 1878951, 2014096, 2145249, 2271036, 2390133, 2501279,
      2603293, 2695089, 2775685, 2844218, 2899951, 2942284, 2970763, 2985080
   };

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
      logic               known;
      logic signed [15:0] want;
   } probe_row_type;

   // Rows with known set carry their result typed in; the rest go through the model.
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      '{16'sh0000, 1'b0, 1'b1, 16'sh0000},
      '{16'sh0000, 1'b1, 1'b1, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b1, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0001, 1'b0, 1'b0, 16'sh0000},
      '{16'shffff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh5555, 1'b0, 1'b0, 16'sh0000},
      '{16'shaaaa, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b1, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b1, 1'b0, 16'sh0000}
   };

   typedef enum int {
      PAT_NOISE,
      PAT_EXTREME,
      PAT_HOLD,
      PAT_SMALL,
      PAT_TOGGLE
   } pattern_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   firlp_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   firlp_pkg::rsp_type rsp_data;

   logic signed [15:0] history [TAPS-1];
   firlp_pkg::rsp_type expected_out [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 idle_pct = IDLE_PCT_DEFAULT;
   int                 stall_pct = IDLE_PCT_DEFAULT;
   bit                 hold_ask = 1'b0;
   logic               held_known = 1'b0;
   logic signed [15:0] held_want = '0;

   fir_lowpass_filter_64tap_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (history[i]) history[i] = '0;
   end

   // Convolve one sample with the quantized taps, then advance the history.
   function automatic firlp_pkg::rsp_type filter_sample(input firlp_pkg::req_type item);
      longint             acc;
      longint             coef;
      longint             y;
      int                 k;
      firlp_pkg::rsp_type r;
      acc = 0;
      for (k = 0; k < TAPS; k++) begin
         coef = LOWPASS_HALF[(k < HALF_TAPS) ? k : (TAPS - 1 - k)];
         coef = ((coef << FRAC_BITS) + DESIGN_SCALE / 2) / DESIGN_SCALE;
         if (k == 0) begin
            acc += coef * longint'(item.sample_in);
         end else begin
            acc += coef * longint'(history[k-1]);
         end
      end
      for (k = TAPS - 2; k > 0; k--) history[k] = history[k-1];
      history[0] = item.sample_in;
      y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.sample_out = y[15:0];
      r.last_out = item.last_in;
      return r;
   endfunction

   always @(posedge clock) begin
      firlp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $error("unexpected result: sample_out %0d last_out %0b",
                      rsp_data.sample_out, rsp_data.last_out);
               mismatch_count++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d",
                         want.sample_out, rsp_data.sample_out);
                  mismatch_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = filter_sample(req_data);
            if (held_known) want.sample_out = held_want;
            expected_out.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_ask) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_ask = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Enter at a falling edge; return at the falling edge after the transfer, valid still high.
   task automatic send_sample(input firlp_pkg::req_type item, input logic known,
                              input logic signed [15:0] want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      held_known = known;
      held_want = want;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      firlp_pkg::req_type item;
      pattern_type        pattern;
      logic signed [15:0] run_level;
      logic signed [15:0] s;
      logic               broken_frame;
      int                 frame_left;
      int                 pick;
      int                 n;
      frame_left = 0;
      pattern = PAT_NOISE;
      run_level = '0;
      broken_frame = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < NUM_PROBES; n++) begin
         item.sample_in = PROBES[n].sample;
         item.last_in = PROBES[n].last;
         send_sample(item, PROBES[n].known, PROBES[n].want);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            // drain the pipe completely before going on
            req_valid <= 1'b0;
            wait (expected_out.size() == 0);
            @(negedge clock);
         end
         if (n == 200) begin
            hold_ask = 1'b1;
            idle_pct = 0;
         end
         if (n == 240) stall_pct = 0;
         if (n == 340) begin
            idle_pct = IDLE_PCT_DEFAULT;
            stall_pct = IDLE_PCT_DEFAULT;
         end

         if (frame_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 45) pattern = PAT_NOISE;
            else if (pick < 60) pattern = PAT_EXTREME;
            else if (pick < 72) pattern = PAT_HOLD;
            else if (pick < 85) pattern = PAT_SMALL;
            else pattern = PAT_TOGGLE;
            frame_left = (pattern == PAT_HOLD) ? $urandom_range(90, 40) : $urandom_range(40, 1);
            broken_frame = ($urandom_range(9) == 0);
            case ($urandom_range(2))
               0: run_level = 16'sh7fff;
               1: run_level = 16'sh8000;
               default: run_level = 16'($urandom);
            endcase
         end

         case (pattern)
            PAT_EXTREME: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            PAT_HOLD:    s = run_level;
            PAT_SMALL:   s = 16'(int'($urandom_range(16)) - 8);
            PAT_TOGGLE:  s = frame_left[0] ? 16'sh7fff : 16'sh8000;
            default:     s = 16'($urandom);
         endcase
         item.sample_in = s;
         item.last_in = broken_frame ? 1'($urandom_range(1)) : (frame_left == 1);
         frame_left--;
         send_sample(item, 1'b0, '0);
      end

      req_valid <= 1'b0;
      wait (expected_out.size() == 0);
      repeat (2 * TAPS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/firlp_pkg.sv
rtl/core/firlp_tap_cell.sv
rtl/core/firlp_mac.sv
rtl/core/fir_lowpass_filter_64tap_top.sv
dv/tb_fir_lowpass_filter_64tap_top.sv
